/* src/mstg_pkg.sv */
`default_nettype none

package mstg_pkg;

    localparam int CHANNELS_DEF      = 4;
    localparam int TONE_CLOCK_DEF    = 8000;
    localparam int FRACTION_BITS_DEF = 6;

    localparam int FUNC_W   = 2;
    localparam int CHAN_W   = 2;
    localparam int NOTE_W   = 8;
    localparam int PHASE_W  = 16;
    localparam int LEVEL_W  = 3;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 8;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

    // semitone frequencies in units of 0.0001 Hz, from 27.5 Hz up
    localparam int FREQ_E4 [12] = '{
        275000, 291353, 308677, 327032, 346479, 367081,
        388909, 412035, 436536, 462493, 489995, 519130
    };

    typedef enum logic [FUNC_W-1:0] {
        FUNC_SET_NOTE = 2'd0,
        FUNC_ADVANCE  = 2'd1,
        FUNC_TICK     = 2'd2
    } t_func;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SET,
        S_ADV_RD,
        S_ADV_CHK,
        S_TICK_RD,
        S_TICK,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

/* src/mstg_chan_ram.sv */
`default_nettype none

module mstg_chan_ram #(
    parameter int CHANNELS = mstg_pkg::CHANNELS_DEF,
    parameter int AW       = 1
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire  [AW-1:0]                i_rd_addr,
    output logic [mstg_pkg::PHASE_W-1:0] o_rd_period,
    output logic [mstg_pkg::PHASE_W-1:0] o_rd_phase,
    input  wire                          i_wr_en,
    input  wire  [AW-1:0]                i_wr_addr,
    input  wire  [mstg_pkg::PHASE_W-1:0] i_wr_period,
    input  wire  [mstg_pkg::PHASE_W-1:0] i_wr_phase
);

    logic [mstg_pkg::PHASE_W-1:0] r_period_mem [CHANNELS];
    logic [mstg_pkg::PHASE_W-1:0] r_phase_mem  [CHANNELS];
    logic [CHANNELS-1:0]          r_valid;
    logic [mstg_pkg::PHASE_W-1:0] r_rd_period;
    logic [mstg_pkg::PHASE_W-1:0] r_rd_phase;
    logic                         r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_period_mem[i_wr_addr] <= i_wr_period;
            r_phase_mem[i_wr_addr]  <= i_wr_phase;
        end
        r_rd_period <= r_period_mem[i_rd_addr];
        r_rd_phase  <= r_phase_mem[i_rd_addr];
    end

    // unwritten entries read as zero (silent, phase cleared)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_period = r_rd_valid ? r_rd_period : '0;
    assign o_rd_phase  = r_rd_valid ? r_rd_phase  : '0;

endmodule

`default_nettype wire

/* src/mstg_note_dec.sv */
`default_nettype none

module mstg_note_dec #(
    parameter int TONE_CLOCK    = mstg_pkg::TONE_CLOCK_DEF,
    parameter int FRACTION_BITS = mstg_pkg::FRACTION_BITS_DEF
) (
    input  wire  [mstg_pkg::NOTE_W-1:0]  i_note_code,
    output logic [mstg_pkg::PHASE_W-1:0] o_period
);

    localparam longint TC = longint'(TONE_CLOCK) * 64'd10000;

    localparam logic [15:0] ROM [12] = '{
        16'((TC / mstg_pkg::FREQ_E4[0])  << FRACTION_BITS),
        16'((TC / mstg_pkg::FREQ_E4[1])  << FRACTION_BITS),
        16'((TC / mstg_pkg::FREQ_E4[2])  << FRACTION_BITS),
        16'((TC / mstg_pkg::FREQ_E4[3])  << FRACTION_BITS),
        16'((TC / mstg_pkg::FREQ_E4[4])  << FRACTION_BITS),
        16'((TC / mstg_pkg::FREQ_E4[5])  << FRACTION_BITS),
        16'((TC / mstg_pkg::FREQ_E4[6])  << FRACTION_BITS),
        16'((TC / mstg_pkg::FREQ_E4[7])  << FRACTION_BITS),
        16'((TC / mstg_pkg::FREQ_E4[8])  << FRACTION_BITS),
        16'((TC / mstg_pkg::FREQ_E4[9])  << FRACTION_BITS),
        16'((TC / mstg_pkg::FREQ_E4[10]) << FRACTION_BITS),
        16'((TC / mstg_pkg::FREQ_E4[11]) << FRACTION_BITS)
    };

    logic [8:0]  m;
    logic [15:0] prod;
    logic [4:0]  octave;
    logic [8:0]  rem_full;
    logic [3:0]  semitone;

    // m / 12 as (m * 171) >> 11, exact for m up to 256
    always_comb begin
        m        = {1'b0, i_note_code} + 9'd1;
        prod     = 16'(m) * 16'd171;
        octave   = prod[15:11];
        rem_full = m - 9'(octave) * 9'd12;
        semitone = rem_full[3:0];
        if (i_note_code == '0 || octave[4]) begin
            o_period = '0;
        end else begin
            o_period = ROM[semitone] >> octave[3:0];
        end
    end

endmodule

`default_nettype wire

/* src/multichannel_square_tone_generator_top.sv */
`default_nettype none

// Channel   Dir  Handshake                  Payload
// s_axis    in   i_s_axis_tvalid/o_..tready  tdata: chan_index, note_code; tuser: func
// m_axis    out  o_m_axis_tvalid/i_..tready  tdata: sample_level
// cfg       in   i_cfg_valid/o_cfg_ready     i_cfg_data: mix_mode
//
// One item at a time: set-note writes one channel, advance probes channels in turn
// (at most CHANNELS probes), tick reads every channel in multitone and only the
// arpeggio channel in arpeggio, one at a time through the single RAM read port.
// The result sits in an output register; a tick waits in its emit state while
// that register is full and not being taken. Synchronous active-low reset; channels read
// as silent until written.

module multichannel_square_tone_generator_top #(
    parameter int CHANNELS      = mstg_pkg::CHANNELS_DEF,
    parameter int TONE_CLOCK    = mstg_pkg::TONE_CLOCK_DEF,
    parameter int FRACTION_BITS = mstg_pkg::FRACTION_BITS_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // [1:0] chan_index, [9:2] note_code
    input  wire  [mstg_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    // [1:0] func
    input  wire  [mstg_pkg::FUNC_W-1:0]      i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  wire                              i_m_axis_tready,
    // [2:0] sample_level
    output logic [mstg_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire                              i_cfg_data
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SW = $clog2(CHANNELS + 1);
    localparam logic [AW-1:0] LAST_CH = AW'(CHANNELS - 1);
    localparam logic [mstg_pkg::PHASE_W-1:0] INC = 16'(1) << FRACTION_BITS;

    mstg_pkg::t_state r_state, n_state;

    logic [AW-1:0]                     r_arp, n_arp;
    logic [SW-1:0]                     r_steps, n_steps;
    logic [AW-1:0]                     r_idx, n_idx;
    logic [mstg_pkg::LEVEL_W-1:0]      r_level, n_level;
    logic [mstg_pkg::CHAN_W-1:0]       r_chan, n_chan;
    logic [mstg_pkg::NOTE_W-1:0]       r_note, n_note;
    logic                              r_mix;
    logic                              r_out_vld, n_out_vld;
    logic [mstg_pkg::LEVEL_W-1:0]      r_out_level, n_out_level;

    logic [AW-1:0]                     rd_addr;
    logic [mstg_pkg::PHASE_W-1:0]      rd_period;
    logic [mstg_pkg::PHASE_W-1:0]      rd_phase;
    logic                              wr_en;
    logic [AW-1:0]                     wr_addr;
    logic [mstg_pkg::PHASE_W-1:0]      wr_period;
    logic [mstg_pkg::PHASE_W-1:0]      wr_phase;
    logic [mstg_pkg::PHASE_W-1:0]      dec_period;

    logic [mstg_pkg::PHASE_W-1:0]      ph_sum;
    logic [mstg_pkg::PHASE_W-1:0]      ph_new;
    logic                              ch_high;
    logic                              tick_last;
    logic                              chan_ok;
    logic                              in_beat;
    logic                              out_beat;

    function automatic logic [AW-1:0] next_ch(input logic [AW-1:0] c);
        next_ch = (c == LAST_CH) ? '0 : AW'(c + 1'b1);
    endfunction

    mstg_chan_ram #(
        .CHANNELS (CHANNELS),
        .AW       (AW)
    ) u_ram (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_addr   (rd_addr),
        .o_rd_period (rd_period),
        .o_rd_phase  (rd_phase),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_period (wr_period),
        .i_wr_phase  (wr_phase)
    );

    mstg_note_dec #(
        .TONE_CLOCK    (TONE_CLOCK),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dec (
        .i_note_code (r_note),
        .o_period    (dec_period)
    );

    assign o_s_axis_tready = (r_state == mstg_pkg::S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {{(mstg_pkg::OUT_DATA_W - mstg_pkg::LEVEL_W){1'b0}}, r_out_level};
    assign in_beat         = i_s_axis_tvalid && o_s_axis_tready;
    assign out_beat        = r_out_vld && i_m_axis_tready;

    // per-channel phase update
    always_comb begin
        ph_sum    = rd_phase + INC;
        ph_new    = (ph_sum > rd_period) ? ph_sum - rd_period : ph_sum;
        ch_high   = (rd_period != '0) && (ph_new > (rd_period >> 1));
        tick_last = r_mix ? (r_idx == LAST_CH) : 1'b1;
        chan_ok   = (int'(r_chan) < CHANNELS);
    end

    always_comb begin
        n_state     = r_state;
        n_arp       = r_arp;
        n_steps     = r_steps;
        n_idx       = r_idx;
        n_level     = r_level;
        n_chan      = r_chan;
        n_note      = r_note;
        n_out_vld   = out_beat ? 1'b0 : r_out_vld;
        n_out_level = r_out_level;
        rd_addr     = r_idx;
        wr_en       = 1'b0;
        wr_addr     = r_idx;
        wr_period   = rd_period;
        wr_phase    = ph_new;

        case (r_state)
            mstg_pkg::S_IDLE: begin
                n_steps = '0;
                n_level = '0;
                n_idx   = r_mix ? '0 : r_arp;
                n_chan  = i_s_axis_tdata[mstg_pkg::CHAN_W-1:0];
                n_note  = i_s_axis_tdata[mstg_pkg::CHAN_W +: mstg_pkg::NOTE_W];
                if (in_beat) begin
                    case (i_s_axis_tuser)
                        mstg_pkg::FUNC_SET_NOTE: n_state = mstg_pkg::S_SET;
                        mstg_pkg::FUNC_ADVANCE:  n_state = mstg_pkg::S_ADV_RD;
                        mstg_pkg::FUNC_TICK:     n_state = mstg_pkg::S_TICK_RD;
                        default:                 n_state = mstg_pkg::S_IDLE;
                    endcase
                end
            end
            mstg_pkg::S_SET: begin
                wr_en     = chan_ok;
                wr_addr   = AW'(r_chan);
                wr_period = dec_period;
                wr_phase  = '0;
                if (chan_ok) begin
                    n_arp = '0;
                end
                n_state = mstg_pkg::S_IDLE;
            end
            mstg_pkg::S_ADV_RD: begin
                rd_addr = next_ch(r_arp);
                n_arp   = next_ch(r_arp);
                n_steps = SW'(r_steps + 1'b1);
                n_state = mstg_pkg::S_ADV_CHK;
            end
            mstg_pkg::S_ADV_CHK: begin
                if (r_steps == SW'(CHANNELS) || rd_period != '0) begin
                    n_state = mstg_pkg::S_IDLE;
                end else begin
                    n_state = mstg_pkg::S_ADV_RD;
                end
            end
            mstg_pkg::S_TICK_RD: begin
                rd_addr = r_idx;
                n_state = mstg_pkg::S_TICK;
            end
            mstg_pkg::S_TICK: begin
                // write back this channel if it has a period, read the next one
                wr_en   = (rd_period != '0);
                rd_addr = next_ch(r_idx);
                n_level = (r_level == mstg_pkg::LEVEL_MAX) ? r_level
                        : r_level + mstg_pkg::LEVEL_W'(ch_high);
                if (tick_last) begin
                    n_state = mstg_pkg::S_EMIT;
                end else begin
                    n_idx = next_ch(r_idx);
                end
            end
            mstg_pkg::S_EMIT: begin
                if (!r_out_vld || i_m_axis_tready) begin
                    n_out_vld   = 1'b1;
                    n_out_level = r_level;
                    n_state     = mstg_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mstg_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= mstg_pkg::S_IDLE;
            r_arp     <= '0;
            r_mix     <= 1'b0;
            r_out_vld <= 1'b0;
            r_steps   <= '0;
        end else begin
            r_state   <= n_state;
            r_arp     <= n_arp;
            r_out_vld <= n_out_vld;
            r_steps   <= n_steps;
            if (i_cfg_valid && o_cfg_ready) begin
                r_mix <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_level     <= n_level;
        r_chan      <= n_chan;
        r_note      <= n_note;
        r_out_level <= n_out_level;
    end

`ifndef ASSERT_OFF
    a_wr_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_state == mstg_pkg::S_SET || r_state == mstg_pkg::S_TICK))
        else $error("channel RAM written outside set or tick");

    a_steps_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_steps) <= CHANNELS)
        else $error("advance probed more channels than exist");

    a_arp_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mstg_pkg::S_TICK && !r_mix) |-> r_idx == r_arp)
        else $error("arpeggio tick on a channel other than the pointer");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state) == mstg_pkg::S_EMIT)
        else $error("result beat raised outside emit");

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mstg_pkg::S_EMIT && !r_mix) |-> r_level <= mstg_pkg::LEVEL_W'(1))
        else $error("arpeggio level above one");
`endif

endmodule

`default_nettype wire

/* verif/tb_multichannel_square_tone_generator_top.sv */
`timescale 1ns / 1ps

module tb_multichannel_square_tone_generator_top;

    localparam int CH        = mstg_pkg::CHANNELS_DEF;
    localparam int TONE_CLK  = mstg_pkg::TONE_CLOCK_DEF;
    localparam int FRAC_BITS = mstg_pkg::FRACTION_BITS_DEF;

    localparam logic [mstg_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    localparam int BEATS_PER_PHASE = 135;
    localparam int SETTLE_CYCLES   = 24;
    localparam int RX_HOLD_CYCLES  = 100;

    typedef struct packed {
        logic                        is_cfg;
        logic                        mode;
        logic [mstg_pkg::FUNC_W-1:0] func;
        logic [mstg_pkg::CHAN_W-1:0] chan;
        logic [mstg_pkg::NOTE_W-1:0] note;
        logic                        known;
        logic [mstg_pkg::LEVEL_W-1:0] level;
    } t_tone_row;

    localparam int DIR_N = 27;
    localparam t_tone_row DIR_ROWS [DIR_N] = '{
        '{1'b1, 1'b0, mstg_pkg::FUNC_SET_NOTE, 2'd0, 8'd0,   1'b0, 3'd0},
        '{1'b0, 1'b0, mstg_pkg::FUNC_TICK,     2'd0, 8'd0,   1'b1, 3'd0},  // arp channel silent
        '{1'b0, 1'b0, FUNC_UNUSED,             2'd3, 8'd255, 1'b0, 3'd0},
        '{1'b0, 1'b0, mstg_pkg::FUNC_ADVANCE,  2'd0, 8'd0,   1'b0, 3'd0},  // nothing enabled
        '{1'b0, 1'b0, mstg_pkg::FUNC_TICK,     2'd0, 8'd0,   1'b1, 3'd0},
        '{1'b0, 1'b0, mstg_pkg::FUNC_SET_NOTE, 2'd0, 8'd255, 1'b0, 3'd0},  // octave too high
        '{1'b0, 1'b0, mstg_pkg::FUNC_TICK,     2'd0, 8'd0,   1'b1, 3'd0},
        '{1'b0, 1'b0, mstg_pkg::FUNC_SET_NOTE, 2'd0, 8'd1,   1'b0, 3'd0},
        '{1'b0, 1'b0, mstg_pkg::FUNC_SET_NOTE, 2'd1, 8'd11,  1'b0, 3'd0},
        '{1'b0, 1'b0, mstg_pkg::FUNC_SET_NOTE, 2'd2, 8'd130, 1'b0, 3'd0},  // tiny period
        '{1'b0, 1'b0, mstg_pkg::FUNC_SET_NOTE, 2'd3, 8'd47,  1'b0, 3'd0},
        '{1'b0, 1'b0, mstg_pkg::FUNC_TICK,     2'd0, 8'd0,   1'b0, 3'd0},
        '{1'b0, 1'b0, mstg_pkg::FUNC_TICK,     2'd0, 8'd0,   1'b0, 3'd0},
        '{1'b0, 1'b0, mstg_pkg::FUNC_ADVANCE,  2'd0, 8'd0,   1'b0, 3'd0},
        '{1'b0, 1'b0, mstg_pkg::FUNC_TICK,     2'd0, 8'd0,   1'b0, 3'd0},
        '{1'b0, 1'b0, mstg_pkg::FUNC_ADVANCE,  2'd0, 8'd0,   1'b0, 3'd0},
        '{1'b0, 1'b0, mstg_pkg::FUNC_TICK,     2'd0, 8'd0,   1'b0, 3'd0},
        '{1'b0, 1'b0, mstg_pkg::FUNC_SET_NOTE, 2'd1, 8'd0,   1'b0, 3'd0},  // silence
        '{1'b0, 1'b0, mstg_pkg::FUNC_ADVANCE,  2'd0, 8'd0,   1'b0, 3'd0},
        '{1'b0, 1'b0, mstg_pkg::FUNC_TICK,     2'd0, 8'd0,   1'b0, 3'd0},
        '{1'b1, 1'b1, mstg_pkg::FUNC_SET_NOTE, 2'd0, 8'd0,   1'b0, 3'd0},
        '{1'b0, 1'b0, mstg_pkg::FUNC_ADVANCE,  2'd0, 8'd0,   1'b0, 3'd0},  // pointer unused here
        '{1'b0, 1'b0, mstg_pkg::FUNC_TICK,     2'd0, 8'd0,   1'b0, 3'd0},
        '{1'b0, 1'b0, mstg_pkg::FUNC_TICK,     2'd0, 8'd0,   1'b0, 3'd0},
        '{1'b0, 1'b0, mstg_pkg::FUNC_TICK,     2'd0, 8'd0,   1'b0, 3'd0},
        '{1'b0, 1'b0, mstg_pkg::FUNC_SET_NOTE, 2'd2, 8'd191, 1'b0, 3'd0},  // octave 16
        '{1'b0, 1'b0, mstg_pkg::FUNC_TICK,     2'd0, 8'd0,   1'b0, 3'd0}
    };

    logic                            i_clk;
    logic                            i_rst_n = 1'b0;
    logic                            i_s_axis_tvalid = 1'b0;
    logic                            o_s_axis_tready;
    logic [mstg_pkg::IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    logic [mstg_pkg::FUNC_W-1:0]     i_s_axis_tuser = '0;
    logic                            o_m_axis_tvalid;
    logic                            i_m_axis_tready = 1'b0;
    logic [mstg_pkg::OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic                            i_cfg_data = 1'b0;

    multichannel_square_tone_generator_top #(
        .CHANNELS      (CH),
        .TONE_CLOCK    (TONE_CLK),
        .FRACTION_BITS (FRAC_BITS)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    // tone model state
    logic [mstg_pkg::PHASE_W-1:0] tone_period [CH];
    logic [mstg_pkg::PHASE_W-1:0] tone_phase  [CH];
    int                           arp_sel;
    logic                         mix_sel;

    logic [mstg_pkg::LEVEL_W-1:0] pending_levels [$];
    int                           errors;
    int                           levels_seen;
    int                           tx_idle_pct;
    int                           rx_idle_pct;
    int                           rx_hold;
    bit                           hold_done;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic logic [mstg_pkg::PHASE_W-1:0] semitone_word(int s);
        longint q;
        q = (longint'(TONE_CLK) * 10000) / mstg_pkg::FREQ_E4[s];
        return mstg_pkg::PHASE_W'(q << FRAC_BITS);
    endfunction

    function automatic bit advance_phase(int c);
        logic [mstg_pkg::PHASE_W-1:0] per;
        logic [mstg_pkg::PHASE_W-1:0] ph;
        per = tone_period[c];
        if (per == '0)
            return 1'b0;
        ph = tone_phase[c] + mstg_pkg::PHASE_W'(1 << FRAC_BITS);
        if (ph > per)
            ph = ph - per;
        tone_phase[c] = ph;
        return ph > (per >> 1);
    endfunction

    // returns the level a beat yields, or -1 when it yields none
    function automatic int tone_predict(logic [mstg_pkg::FUNC_W-1:0] f,
                                        logic [mstg_pkg::CHAN_W-1:0] c,
                                        logic [mstg_pkg::NOTE_W-1:0] n);
        int m;
        int oct;
        int t;
        int lvl;
        lvl = -1;
        case (f)
            mstg_pkg::FUNC_SET_NOTE: begin
                if (int'(c) < CH) begin
                    tone_phase[c] = '0;
                    arp_sel = 0;
                    if (n == '0) begin
                        tone_period[c] = '0;
                    end else begin
                        m = int'(n) + 1;
                        oct = m / 12;
                        tone_period[c] = (oct >= 16) ? '0 : semitone_word(m % 12) >> oct;
                    end
                end
            end
            mstg_pkg::FUNC_ADVANCE: begin
                t = 0;
                do begin
                    arp_sel = (arp_sel == CH - 1) ? 0 : arp_sel + 1;
                    t++;
                end while (t != CH && tone_period[arp_sel] == '0);
            end
            mstg_pkg::FUNC_TICK: begin
                lvl = 0;
                if (mix_sel) begin
                    for (int i = 0; i < CH; i++)
                        if (advance_phase(i))
                            lvl++;
                end else if (advance_phase(arp_sel)) begin
                    lvl = 1;
                end
                if (lvl > int'(mstg_pkg::LEVEL_MAX))
                    lvl = int'(mstg_pkg::LEVEL_MAX);
            end
            default: ;
        endcase
        return lvl;
    endfunction

    task automatic put_beat(logic [mstg_pkg::FUNC_W-1:0] f, logic [mstg_pkg::CHAN_W-1:0] c,
                            logic [mstg_pkg::NOTE_W-1:0] n, bit known,
                            logic [mstg_pkg::LEVEL_W-1:0] lv);
        int res;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= mstg_pkg::IN_DATA_W'({n, c});
        i_s_axis_tuser  <= f;
        do @(posedge i_clk); while (!o_s_axis_tready);
        res = tone_predict(f, c, n);
        if (res >= 0)
            pending_levels.push_back(known ? lv : mstg_pkg::LEVEL_W'(res));
    endtask

    task automatic drain(int extra);
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_levels.size() != 0)
            @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_mix(logic v);
        drain(SETTLE_CYCLES);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        mix_sel = v;
    endtask

    // sample sink: random stalls, one long hold-off, checks each beat
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                levels_seen++;
                if (pending_levels.size() == 0) begin
                    $display("%0t: unexpected sample beat, expected none, got %0d",
                             $time, o_m_axis_tdata);
                    errors++;
                end else begin
                    logic [mstg_pkg::LEVEL_W-1:0] exp_lvl;
                    exp_lvl = pending_levels.pop_front();
                    if (o_m_axis_tdata !== mstg_pkg::OUT_DATA_W'(exp_lvl)) begin
                        $display("%0t: sample_level mismatch, expected %0d, got %0d",
                                 $time, exp_lvl, o_m_axis_tdata);
                        errors++;
                    end
                end
            end
            if (!hold_done && levels_seen >= 20) begin
                hold_done = 1'b1;
                rx_hold = RX_HOLD_CYCLES;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial begin
        logic [mstg_pkg::FUNC_W-1:0] f;
        logic [mstg_pkg::NOTE_W-1:0] n;
        int r;
        int cnt;
        bit paused;

        for (int i = 0; i < CH; i++) begin
            tone_period[i] = '0;
            tone_phase[i]  = '0;
        end
        arp_sel     = 0;
        mix_sel     = 1'b0;
        errors      = 0;
        levels_seen = 0;
        rx_hold     = 0;
        hold_done   = 1'b0;
        paused      = 1'b0;
        tx_idle_pct = 14;
        rx_idle_pct = 52;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIR_ROWS[k]) begin
            if (DIR_ROWS[k].is_cfg)
                write_mix(DIR_ROWS[k].mode);
            else
                put_beat(DIR_ROWS[k].func, DIR_ROWS[k].chan, DIR_ROWS[k].note,
                         DIR_ROWS[k].known, DIR_ROWS[k].level);
        end

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    tx_idle_pct = 14;
                    rx_idle_pct = 52;
                end
                1: begin
                    tx_idle_pct = 52;
                    rx_idle_pct = 14;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            write_mix((ph == 0) ? 1'b1 : (ph == 1) ? 1'b0 : 1'($urandom_range(1)));
            cnt = 0;
            while (cnt < BEATS_PER_PHASE) begin
                if (ph == 1 && cnt == 60 && !paused) begin
                    paused = 1'b1;
                    drain(0);
                end
                r = $urandom_range(99);
                if (r < 68)
                    f = mstg_pkg::FUNC_TICK;
                else if (r < 82)
                    f = mstg_pkg::FUNC_SET_NOTE;
                else if (r < 96)
                    f = mstg_pkg::FUNC_ADVANCE;
                else
                    f = FUNC_UNUSED;
                // mostly notes with short periods so the waves toggle often
                if ($urandom_range(9) < 7)
                    n = mstg_pkg::NOTE_W'($urandom_range(110, 55));
                else
                    n = mstg_pkg::NOTE_W'($urandom_range(255));
                put_beat(f, mstg_pkg::CHAN_W'($urandom_range(3)), n, 1'b0, '0);
                if (f != FUNC_UNUSED)
                    cnt++;
            end
        end

        drain(SETTLE_CYCLES);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* multichannel_square_tone_generator_top.f */
src/mstg_pkg.sv
src/mstg_chan_ram.sv
src/mstg_note_dec.sv
src/multichannel_square_tone_generator_top.sv
verif/tb_multichannel_square_tone_generator_top.sv
